// ===== rtl/imusfp_pkg.sv =====
// ----------------------------------------------------------------------------
// IMU serial frame parser - shared package
// Mode codes, header and type bytes, frame geometry, and the structs passed
// between the framer, the decoder and the top level.
// ----------------------------------------------------------------------------
package imusfp_pkg;

   // framing modes, as written to the mode register
   typedef enum logic [1:0] {
      MODE_TTL   = 2'd0,
      MODE_CAN   = 2'd1,
      MODE_RS485 = 2'd2,
      MODE_OFF   = 2'd3
   } mode_type;

   // header and type bytes
   localparam logic [7:0] HDR_SERIAL = 8'h55;
   localparam logic [7:0] HDR_MODBUS = 8'h50;
   localparam logic [7:0] TYPE_ACC   = 8'h51;
   localparam logic [7:0] TYPE_RATE  = 8'h52;
   localparam logic [7:0] TYPE_ANG   = 8'h53;
   localparam logic [7:0] TYPE_MAG   = 8'h54;

   // frame geometry
   localparam int         FRAME_DEPTH = 11;
   localparam int         CNT_W       = 4;
   localparam logic [3:0] LEN_LONG    = 4'd11;
   localparam logic [3:0] LEN_SHORT   = 4'd8;
   localparam logic [3:0] SUM_BYTES   = 4'd10;   // bytes covered by the TTL checksum

   // quantity codes
   localparam logic [2:0] QTY_ACC     = 3'd0;
   localparam logic [2:0] QTY_RATE    = 3'd1;
   localparam logic [2:0] QTY_ANGLE   = 3'd2;
   localparam logic [2:0] QTY_MAG     = 3'd3;
   localparam logic [2:0] QTY_UNKNOWN = 3'd4;

   typedef logic [FRAME_DEPTH-1:0][7:0] frame_type;

   // completed-frame event from the framer
   typedef struct packed {
      logic       done;
      mode_type   mode;
      logic [1:0] slot;
      logic       sum_ok;
      frame_type  bytes;
   } frame_evt_type;

   // decoded result
   typedef struct packed {
      logic               emit;
      logic [2:0]         quantity;
      logic signed [15:0] value_x;
      logic signed [15:0] value_y;
      logic signed [15:0] value_z;
      logic               checksum_ok;
      logic               values_valid;
      logic               angle_ready;
   } result_type;

endpackage

// ===== rtl/imusfp_framer.sv =====
// ----------------------------------------------------------------------------
// IMU serial frame parser - framer
// Stores received bytes, tracks the byte count, the running TTL checksum and
// the RS485 slot, and flags a completed frame together with its bytes.
// ----------------------------------------------------------------------------
module imusfp_framer
   import imusfp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic [7:0]    rx_byte,
   input  mode_type      mode,
   output frame_evt_type evt
);

   logic [7:0]       fs_ff [FRAME_DEPTH];
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       sum_ff, sum_in;
   logic [1:0]       slot_ff, slot_in;

   logic [CNT_W-1:0] idx;
   logic [CNT_W-1:0] cnt_inc;
   logic [CNT_W-1:0] need;
   logic             store;
   logic             active;
   logic [7:0]       hdr;
   logic             hdr_ok;
   logic             done;
   frame_type        view;

   assign idx    = cnt_ff;
   assign active = step && (mode != MODE_OFF);
   assign store  = idx < CNT_W'(FRAME_DEPTH);

   // frame bytes with the incoming byte already in place
   always_comb begin
      for (int k = 0; k < FRAME_DEPTH; k++) begin
         if (store && idx == CNT_W'(k)) begin
            view[k] = rx_byte;
         end else begin
            view[k] = fs_ff[k];
         end
      end
   end

   // count, header and completion
   always_comb begin
      cnt_inc = (cnt_ff >= CNT_W'(FRAME_DEPTH)) ? CNT_W'(FRAME_DEPTH) : cnt_ff + 1'b1;
      hdr     = (mode == MODE_RS485) ? HDR_MODBUS : HDR_SERIAL;
      hdr_ok  = (view[0] == hdr);
      need    = (mode == MODE_CAN) ? LEN_SHORT : LEN_LONG;
      done    = active && hdr_ok && (cnt_inc >= need);

      cnt_in = cnt_ff;
      if (step) begin
         if (mode == MODE_OFF || !hdr_ok || cnt_inc >= need) begin
            cnt_in = '0;
         end else begin
            cnt_in = cnt_inc;
         end
      end
   end

   // running sum over the checksum-covered bytes
   always_comb begin
      sum_in = sum_ff;
      if (active && idx < SUM_BYTES) begin
         sum_in = (idx == '0) ? rx_byte : sum_ff + rx_byte;
      end
   end

   // RS485 slot rotates on each completed reply
   assign slot_in = (done && mode == MODE_RS485) ? slot_ff + 2'd1 : slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         slot_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         slot_ff <= slot_in;
      end
   end

   // byte store and sum, no reset needed
   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      for (int k = 0; k < FRAME_DEPTH; k++) begin
         if (active && store && idx == CNT_W'(k)) begin
            fs_ff[k] <= rx_byte;
         end
      end
   end

   assign evt.done   = done;
   assign evt.mode   = mode;
   assign evt.slot   = slot_ff;
   assign evt.sum_ok = (sum_ff == rx_byte);
   assign evt.bytes  = view;

endmodule

// ===== rtl/imusfp_decoder.sv =====
// ----------------------------------------------------------------------------
// IMU serial frame parser - decoder
// Turns a completed frame into a result: quantity, three values and flags.
// ----------------------------------------------------------------------------
module imusfp_decoder
   import imusfp_pkg::*;
(
   input  frame_evt_type evt,
   output result_type    res
);

   logic       known;
   logic [2:0] type_q;
   logic [2:0] slot_q;
   logic [7:0] t;

   assign t = evt.bytes[1];

   // type byte lookup for TTL and CAN
   always_comb begin
      known  = 1'b1;
      type_q = QTY_UNKNOWN;
      priority if (t == TYPE_ACC) begin
         type_q = QTY_ACC;
      end else if (t == TYPE_RATE) begin
         type_q = QTY_RATE;
      end else if (t == TYPE_ANG) begin
         type_q = QTY_ANGLE;
      end else if (t == TYPE_MAG) begin
         type_q = QTY_MAG;
      end else begin
         known = 1'b0;
      end
   end

   // RS485 slot order: acc, rate, mag, angle
   always_comb begin
      unique case (evt.slot)
         2'd0:    slot_q = QTY_ACC;
         2'd1:    slot_q = QTY_RATE;
         2'd2:    slot_q = QTY_MAG;
         default: slot_q = QTY_ANGLE;
      endcase
   end

   // result assembly
   always_comb begin
      res = '0;
      if (evt.mode == MODE_RS485) begin
         res.emit         = evt.done;
         res.quantity     = slot_q;
         res.value_x      = {evt.bytes[3], evt.bytes[4]};
         res.value_y      = {evt.bytes[5], evt.bytes[6]};
         res.value_z      = {evt.bytes[7], evt.bytes[8]};
         res.checksum_ok  = 1'b1;
         res.values_valid = 1'b1;
         res.angle_ready  = (slot_q == QTY_ANGLE);
      end else begin
         res.value_x = {evt.bytes[3], evt.bytes[2]};
         res.value_y = {evt.bytes[5], evt.bytes[4]};
         res.value_z = {evt.bytes[7], evt.bytes[6]};
         if (evt.mode == MODE_TTL) begin
            // unknown type in TTL is dropped
            res.emit         = evt.done && known;
            res.quantity     = type_q;
            res.checksum_ok  = evt.sum_ok;
            res.values_valid = evt.sum_ok;
         end else begin
            res.emit         = evt.done;
            res.quantity     = known ? type_q : QTY_UNKNOWN;
            res.checksum_ok  = 1'b1;
            res.values_valid = known;
         end
         res.angle_ready = (res.quantity == QTY_ANGLE) && res.values_valid;
      end
   end

endmodule

// ===== rtl/imu_serial_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// IMU serial frame parser - top level
// Byte input register, framer, decoder and result register.
// ----------------------------------------------------------------------------
// Takes one received byte per beat on req_ and frames sensor packets in TTL
// (11 bytes, header 0x55, additive checksum), CAN (8 bytes, header 0x55) or
// RS485 (11 bytes, header 0x50, rotating quantity slot) mode, chosen by the
// mode register on csr_; mode 3 discards every byte. A byte can be taken
// every cycle unless the result register holds up the input. A byte is
// registered in the input register, where it is framed and decoded in one
// pass, and a completed frame of a type that is not dropped is loaded into
// the result register, which holds rsp_valid until it is taken. The result
// register is the only thing that can hold up the input: while a result
// waits on rsp_ready, one more byte is still taken into the input register,
// then req_ready drops whether or not that byte completes a frame. Write the
// mode only while no byte or result is held in the block; a partly received
// frame carries over and completes at the new mode's length.
// ----------------------------------------------------------------------------
module imu_serial_frame_parser_core
   import imusfp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // byte input
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   // result output
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_quantity,
   output logic signed [15:0] rsp_value_x,
   output logic signed [15:0] rsp_value_y,
   output logic signed [15:0] rsp_value_z,
   output logic               rsp_checksum_ok,
   output logic               rsp_values_valid,
   output logic               rsp_angle_ready,
   // mode register
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_protocol_mode
);

   mode_type      mode_ff, mode_in;
   logic          in_v_ff, in_v_in;
   logic [7:0]    rx_ff, rx_in;
   logic          out_v_ff, out_v_in;
   result_type    out_ff, out_in;
   logic          advance;
   frame_evt_type evt;
   result_type    res;

   // mode register
   assign csr_ready = 1'b1;
   assign mode_in   = (csr_valid && csr_ready) ? mode_type'(csr_protocol_mode) : mode_ff;

   // input stage moves on when the result register can take a beat
   assign advance   = in_v_ff && (!out_v_ff || rsp_ready);
   assign req_ready = !in_v_ff || advance;

   always_comb begin
      in_v_in = in_v_ff;
      rx_in   = rx_ff;
      if (req_valid && req_ready) begin
         in_v_in = 1'b1;
         rx_in   = req_rx_byte;
      end else if (advance) begin
         in_v_in = 1'b0;
      end
   end

   imusfp_framer u_framer (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (rx_ff),
      .mode    (mode_ff),
      .evt     (evt)
   );

   imusfp_decoder u_decoder (
      .evt (evt),
      .res (res)
   );

   // result register
   always_comb begin
      out_v_in = out_v_ff;
      out_in   = out_ff;
      if (advance && res.emit) begin
         out_v_in = 1'b1;
         out_in   = res;
      end else if (rsp_ready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_TTL;
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         in_v_ff  <= in_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      rx_ff  <= rx_in;
      out_ff <= out_in;
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_quantity     = out_ff.quantity;
   assign rsp_value_x      = out_ff.value_x;
   assign rsp_value_y      = out_ff.value_y;
   assign rsp_value_z      = out_ff.value_z;
   assign rsp_checksum_ok  = out_ff.checksum_ok;
   assign rsp_values_valid = out_ff.values_valid;
   assign rsp_angle_ready  = out_ff.angle_ready;

   // input stalls only behind a held byte and a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_v_ff && out_v_ff && !rsp_ready)
      else $error("input stalled without a pending result");

   // an accepted byte is in the input register next cycle
   a_byte_held: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> in_v_ff && rx_ff == $past(req_rx_byte))
      else $error("accepted byte not captured");

   // angle flag only with a valid angle result
   a_angle_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_angle_ready |-> rsp_quantity == QTY_ANGLE && rsp_values_valid)
      else $error("angle flag on a non-angle or invalid result");

   // unknown type only from CAN framing: checksum ok, values not valid
   a_unknown: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_quantity == QTY_UNKNOWN |-> rsp_checksum_ok && !rsp_values_valid)
      else $error("bad flags on unknown-type result");

endmodule

// ===== tb/imu_serial_frame_parser_core_tb.sv =====
// ----------------------------------------------------------------------------
// IMU serial frame parser core - testbench
// Sends serial bytes into the parser in TTL, CAN, RS485 and off modes and
// decodes every accepted byte in a frame tracker of its own. Each result beat
// is compared field by field with the oldest decoded frame. A directed opening
// is followed by random frames, broken frames and noise under three stall
// profiles. One long result stall backs the parser up into its input.
// ----------------------------------------------------------------------------
module imu_serial_frame_parser_core_tb
   import imusfp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT  = 4000;   // cycles with no beat on any channel
   localparam int HOLD_CYCLES  = 300;    // long result stall
   localparam int DRAIN_CYCLES = 4;      // lets the input and result registers drain
   localparam int END_CYCLES   = 8;
   localparam int SEG_BYTES    = 110;

   // quantity named by each RS485 slot, slot 0 in the low bits
   localparam logic [3:0][2:0] RS485_SLOT_QTY = {QTY_ANGLE, QTY_MAG, QTY_RATE, QTY_ACC};
   localparam logic [3:0][7:0] KNOWN_TYPES    = {TYPE_MAG, TYPE_ANG, TYPE_RATE, TYPE_ACC};
   localparam logic [3:0][7:0] EDGE_BYTES     = {8'h80, 8'h7F, 8'hFF, 8'h00};

   typedef struct packed {
      logic [2:0]         quantity;
      logic signed [15:0] value_x;
      logic signed [15:0] value_y;
      logic signed [15:0] value_z;
      logic               checksum_ok;
      logic               values_valid;
      logic               angle_ready;
   } frame_result_type;

   // -------------------------------------------------------------------------
   // Frame tracker: collects bytes like the parser and holds decoded frames due
   // -------------------------------------------------------------------------
   class imu_frame_tracker_type;
      logic [7:0]       frame_bytes [FRAME_DEPTH];
      logic [3:0]       fill;
      logic [1:0]       slot;
      mode_type         mode;
      frame_result_type frames_due [$];
      int               mismatch_count;
      int               results_seen;

      function new();
         fill = '0;
         slot = '0;
         mode = MODE_TTL;
         mismatch_count = 0;
         results_seen = 0;
         foreach (frame_bytes[i]) frame_bytes[i] = '0;
      endfunction

      function void set_mode(mode_type m);
         mode = m;
      endfunction

      // one accepted byte; queues a decoded frame when one completes
      function void take_byte(logic [7:0] b);
         logic [7:0]       hdr;
         logic [3:0]       need;
         logic [7:0]       sum;
         logic             known;
         frame_result_type r;
         if (mode == MODE_OFF) begin
            fill = '0;
            return;
         end
         if (fill < LEN_LONG) begin
            frame_bytes[fill] = b;
            fill = fill + 4'd1;
         end
         hdr = (mode == MODE_RS485) ? HDR_MODBUS : HDR_SERIAL;
         if (frame_bytes[0] != hdr) begin
            fill = '0;
            return;
         end
         need = (mode == MODE_CAN) ? LEN_SHORT : LEN_LONG;
         if (fill < need) return;
         fill = '0;

         r = '0;
         r.checksum_ok  = 1'b1;
         r.values_valid = 1'b1;
         if (mode == MODE_RS485) begin
            // big-endian values, quantity from the rotating slot
            r.quantity    = RS485_SLOT_QTY[slot];
            r.angle_ready = (r.quantity == QTY_ANGLE);
            slot          = slot + 2'd1;
            r.value_x     = {frame_bytes[3], frame_bytes[4]};
            r.value_y     = {frame_bytes[5], frame_bytes[6]};
            r.value_z     = {frame_bytes[7], frame_bytes[8]};
         end else begin
            known = 1'b1;
            case (frame_bytes[1])
               TYPE_ACC:  r.quantity = QTY_ACC;
               TYPE_RATE: r.quantity = QTY_RATE;
               TYPE_ANG:  r.quantity = QTY_ANGLE;
               TYPE_MAG:  r.quantity = QTY_MAG;
               default:   known = 1'b0;
            endcase
            if (mode == MODE_TTL) begin
               // unknown TTL type is dropped without a result
               if (!known) return;
               sum = '0;
               for (int i = 0; i < SUM_BYTES; i++) sum = sum + frame_bytes[i];
               r.checksum_ok  = (sum == frame_bytes[10]);
               r.values_valid = r.checksum_ok;
            end else if (!known) begin
               r.quantity     = QTY_UNKNOWN;
               r.values_valid = 1'b0;
            end
            r.angle_ready = (r.quantity == QTY_ANGLE) && r.values_valid;
            r.value_x     = {frame_bytes[3], frame_bytes[2]};
            r.value_y     = {frame_bytes[5], frame_bytes[4]};
            r.value_z     = {frame_bytes[7], frame_bytes[6]};
         end
         frames_due = {frames_due, r};
      endfunction

      task report(string msg);
         mismatch_count++;
         $display("MISMATCH: %s", msg);
      endtask

      task check_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want) report($sformatf("result %0d %s got %0h want %0h",
                                            results_seen, name, got, want));
      endtask

      // one result beat against the oldest decoded frame
      task match_result(frame_result_type got);
         frame_result_type want;
         if (frames_due.size() == 0) begin
            report($sformatf("result beat with no frame due, quantity %0d", got.quantity));
            return;
         end
         want = frames_due.pop_front();
         check_field("quantity", 16'(got.quantity), 16'(want.quantity));
         check_field("value_x", got.value_x, want.value_x);
         check_field("value_y", got.value_y, want.value_y);
         check_field("value_z", got.value_z, want.value_z);
         check_field("checksum_ok", 16'(got.checksum_ok), 16'(want.checksum_ok));
         check_field("values_valid", 16'(got.values_valid), 16'(want.values_valid));
         check_field("angle_ready", 16'(got.angle_ready), 16'(want.angle_ready));
         results_seen++;
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Signals and DUT
   // -------------------------------------------------------------------------
   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_rx_byte;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [2:0]         rsp_quantity;
   logic signed [15:0] rsp_value_x;
   logic signed [15:0] rsp_value_y;
   logic signed [15:0] rsp_value_z;
   logic               rsp_checksum_ok;
   logic               rsp_values_valid;
   logic               rsp_angle_ready;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_protocol_mode;

   imu_frame_tracker_type tracker;
   frame_result_type      seen;
   mode_type              cur_mode;
   int                    send_idle_pct;
   int                    recv_idle_pct;
   logic                  hold_off;
   int                    bytes_accepted;
   int                    quiet_cycles;

   imu_serial_frame_parser_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_quantity      (rsp_quantity),
      .rsp_value_x       (rsp_value_x),
      .rsp_value_y       (rsp_value_y),
      .rsp_value_z       (rsp_value_z),
      .rsp_checksum_ok   (rsp_checksum_ok),
      .rsp_values_valid  (rsp_values_valid),
      .rsp_angle_ready   (rsp_angle_ready),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_protocol_mode (csr_protocol_mode)
   );

   // 8 ns clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver: random stalls, or a solid hold-off
   always @(negedge clock) begin
      rsp_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
   end

   // all tracking at the rising edge: results first, then the byte, then mode
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen.quantity     = rsp_quantity;
            seen.value_x      = rsp_value_x;
            seen.value_y      = rsp_value_y;
            seen.value_z      = rsp_value_z;
            seen.checksum_ok  = rsp_checksum_ok;
            seen.values_valid = rsp_values_valid;
            seen.angle_ready  = rsp_angle_ready;
            tracker.match_result(seen);
         end
         if (req_valid && req_ready) begin
            tracker.take_byte(req_rx_byte);
            bytes_accepted++;
         end
         if (csr_valid && csr_ready) tracker.set_mode(mode_type'(csr_protocol_mode));
      end
   end

   // watchdog on cycles with no beat anywhere
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
         $display("imu_serial_frame_parser_core verification failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------

   // one byte beat; entered and left at a falling edge, valid left high
   task send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // mode write once nothing is in flight
   task write_mode(input mode_type m);
      req_valid <= 1'b0;
      while (tracker.frames_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_valid         <= 1'b1;
      csr_protocol_mode <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_mode  = m;
   endtask

   task hold_rsp(input int cycles);
      hold_off = 1'b1;
      repeat (cycles) @(posedge clock);
      hold_off = 1'b0;
   endtask

   function automatic logic [7:0] sum_of(logic [7:0] q [$]);
      logic [7:0] s;
      s = '0;
      foreach (q[i]) s = s + q[i];
      return s;
   endfunction

   // value bytes lean toward the 16-bit extremes now and then
   function automatic logic [7:0] data_byte();
      if ($urandom_range(7) == 0) return EDGE_BYTES[2'($urandom_range(3))];
      return 8'($urandom_range(255));
   endfunction

   // a well-formed frame for the current mode, a cut-off frame, or noise
   task send_chunk(output int sent);
      logic [7:0] chunk [$];
      int         pick;
      pick = $urandom_range(99);
      if (pick < 75) begin
         if (cur_mode == MODE_RS485) begin
            chunk = {chunk, HDR_MODBUS};
            repeat (10) chunk = {chunk, data_byte()};
         end else begin
            chunk = {chunk, HDR_SERIAL};
            if ($urandom_range(99) < 85) chunk = {chunk, KNOWN_TYPES[2'($urandom_range(3))]};
            else chunk = {chunk, 8'($urandom_range(255))};
            if (cur_mode == MODE_CAN) begin
               repeat (6) chunk = {chunk, data_byte()};
            end else begin
               repeat (8) chunk = {chunk, data_byte()};
               if ($urandom_range(99) < 85) chunk = {chunk, sum_of(chunk)};
               else chunk = {chunk, sum_of(chunk) + 8'($urandom_range(1, 255))};
            end
         end
      end else if (pick < 85) begin
         chunk = {chunk, (cur_mode == MODE_RS485) ? HDR_MODBUS : HDR_SERIAL};
         repeat ($urandom_range(1, 6)) chunk = {chunk, data_byte()};
      end else begin
         repeat ($urandom_range(1, 3)) chunk = {chunk, 8'($urandom_range(255))};
      end
      foreach (chunk[i]) send_byte(chunk[i]);
      sent = chunk.size();
   endtask

   // one stall profile over every mode, then random modes
   task run_phase(input int send_pct, input int recv_pct, input bit long_stall);
      int       seg;
      int       counted;
      int       sent;
      mode_type m;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (seg = 0; seg < 6; seg++) begin
         case (seg)
            0:       m = MODE_TTL;
            1:       m = MODE_CAN;
            2:       m = MODE_RS485;
            3:       m = MODE_OFF;
            default: m = mode_type'($urandom_range(2));
         endcase
         write_mode(m);
         if (long_stall && seg == 1) begin
            fork
               hold_rsp(HOLD_CYCLES);
            join_none
         end
         if (m == MODE_OFF) begin
            repeat (12) send_byte(8'($urandom_range(255)));
         end else begin
            counted = 0;
            while (counted < SEG_BYTES) begin
               send_chunk(sent);
               counted += sent;
            end
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [7:0] frame [$];
      tracker           = new();
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_rx_byte       = '0;
      rsp_ready         = 1'b0;
      csr_valid         = 1'b0;
      csr_protocol_mode = MODE_TTL;
      cur_mode          = MODE_TTL;
      send_idle_pct     = 0;
      recv_idle_pct     = 30;
      hold_off          = 1'b0;
      bytes_accepted    = 0;
      quiet_cycles      = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      write_mode(MODE_TTL);
      // stray byte: header mismatch restarts
      send_byte(8'h00);
      // TTL angle frame with most negative, most positive and minus one
      frame = '{HDR_SERIAL, TYPE_ANG, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'h12, 8'h34};
      frame = {frame, sum_of(frame)};
      foreach (frame[i]) send_byte(frame[i]);
      // nine TTL bytes, then CAN mode completes the frame on the next byte
      frame = '{HDR_SERIAL, TYPE_RATE, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07};
      foreach (frame[i]) send_byte(frame[i]);
      write_mode(MODE_CAN);
      send_byte(8'hA5);
      // CAN frame of unknown type
      frame = '{HDR_SERIAL, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h34, 8'h12};
      foreach (frame[i]) send_byte(frame[i]);
      // off mode drops everything
      write_mode(MODE_OFF);
      send_byte(HDR_SERIAL);
      send_byte(HDR_MODBUS);
      // RS485 reply, slot starts at acceleration
      write_mode(MODE_RS485);
      frame = '{HDR_MODBUS, 8'h03, 8'h06, 8'h80, 8'h00, 8'h7F, 8'hFF, 8'h00, 8'h01, 8'hC4,
                8'h0B};
      foreach (frame[i]) send_byte(frame[i]);

      run_phase(38, 68, 1'b0);
      run_phase(68, 38, 1'b0);
      run_phase(0, 0, 1'b1);

      // drain
      req_valid <= 1'b0;
      while (tracker.frames_due.size() != 0) @(negedge clock);
      repeat (END_CYCLES) @(negedge clock);
      if (tracker.frames_due.size() != 0)
         tracker.report($sformatf("%0d decoded frames never came out",
                                  tracker.frames_due.size()));

      $display("Checked %0d results from %0d accepted bytes in TTL, CAN, RS485 and off modes",
               tracker.results_seen, bytes_accepted);
      $display("with mode switches mid-frame, three stall profiles and a %0d-cycle result stall",
               HOLD_CYCLES);
      if (tracker.mismatch_count == 0)
         $display("imu_serial_frame_parser_core verification clean");
      else
         $display("imu_serial_frame_parser_core verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/imusfp_pkg.sv
rtl/imusfp_framer.sv
rtl/imusfp_decoder.sv
rtl/imu_serial_frame_parser_core.sv
tb/imu_serial_frame_parser_core_tb.sv
